### rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the sub-addressed I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd5;

    // bus segment the sequencer is in
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_SETUP,
        PH_ST_HOLD,
        PH_RS_LOW,
        PH_RS_SETUP,
        PH_RS_HOLD,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_TXACK_LOW,
        PH_TXACK_HIGH,
        PH_WAIT,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_RXACK_LOW,
        PH_RXACK_HIGH,
        PH_SP_LOW,
        PH_SP_HIGH,
        PH_SP_DONE
    } phase_t;

    // which byte a transmit phase is sending
    typedef enum logic [1:0] {
        KIND_ADDR_W,
        KIND_SUB,
        KIND_ADDR_R,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        phase_t     phase;
        kind_t      kind;
        logic [3:0] bit_index;
        logic [7:0] bytes_left;
        logic [7:0] shift_byte;
        logic [7:0] tick_count;
        logic       scl_level;
        logic       sda_level;
        logic [6:0] addr_hold;
        logic [7:0] subaddr_hold;
        logic       read_flag;
        logic       ack_seen;
    } seq_state_t;

    // idle with both bus lines released
    localparam seq_state_t SEQ_RESET = '{
        phase:        PH_IDLE,
        kind:         KIND_ADDR_W,
        bit_index:    4'd0,
        bytes_left:   8'd0,
        shift_byte:   8'd0,
        tick_count:   8'd0,
        scl_level:    1'b1,
        sda_level:    1'b1,
        addr_hold:    7'd0,
        subaddr_hold: 8'd0,
        read_flag:    1'b0,
        ack_seen:     1'b0
    };

    typedef struct packed {
        logic       sda_in;
        logic       wr_data_valid;
        logic [7:0] wr_data;
        logic [7:0] byte_count;
        logic [7:0] sub_addr;
        logic [6:0] slave_addr;
        logic       mode;
        logic       start_req;
    } tick_in_t;

    typedef struct packed {
        logic       success;
        logic       done_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       need_data;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } tick_out_t;

endpackage
`default_nettype wire

### rtl/core/i2cm_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state and bus drive logic for one timing tick of the I2C master.
// ----------------------------------------------------------------------------
module i2cm_step
    import i2cm_pkg::*;
(
    input  wire seq_state_t  cur_state,
    input  wire tick_in_t    tick_in,
    input  wire logic [7:0]  half_period,
    output seq_state_t nxt_state,
    output tick_out_t  tick_out
);

    logic [7:0] h_eff;
    logic [8:0] tick_inc;
    logic [3:0] bit_inc;
    logic [7:0] bytes_dec;
    logic       rdv;
    logic       done;

    assign h_eff     = (half_period == 8'd0) ? 8'd1 : half_period;
    assign tick_inc  = {1'b0, cur_state.tick_count} + 9'd1;
    assign bit_inc   = cur_state.bit_index + 4'd1;
    assign bytes_dec = cur_state.bytes_left - 8'd1;

    always_comb begin
        nxt_state = cur_state;
        rdv       = 1'b0;
        done      = 1'b0;
        unique case (cur_state.phase)
            PH_IDLE: begin
                if (tick_in.start_req) begin
                    nxt_state.addr_hold    = tick_in.slave_addr;
                    nxt_state.subaddr_hold = tick_in.sub_addr;
                    nxt_state.bytes_left   = (tick_in.byte_count == 8'd0) ?
                                             8'd1 : tick_in.byte_count;
                    nxt_state.read_flag    = tick_in.mode;
                    nxt_state.ack_seen     = 1'b0;
                    nxt_state.tick_count   = 8'd0;
                    nxt_state.phase        = PH_ST_SETUP;
                    nxt_state.scl_level    = 1'b1;
                    nxt_state.sda_level    = 1'b1;
                end
            end
            PH_WAIT: begin
                if (tick_in.wr_data_valid) begin
                    nxt_state.tick_count = 8'd0;
                    nxt_state.shift_byte = tick_in.wr_data;
                    nxt_state.bit_index  = 4'd0;
                    nxt_state.kind       = KIND_DATA;
                    nxt_state.phase      = PH_TX_LOW;
                    nxt_state.scl_level  = 1'b0;
                    nxt_state.sda_level  = tick_in.wr_data[7];
                end
            end
            default: begin
                if (tick_inc < {1'b0, h_eff}) begin
                    nxt_state.tick_count = tick_inc[7:0];
                end else begin
                    // end of segment
                    nxt_state.tick_count = 8'd0;
                    unique case (cur_state.phase)
                        PH_ST_SETUP: begin
                            nxt_state.phase     = PH_ST_HOLD;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b0;
                        end
                        PH_ST_HOLD: begin
                            nxt_state.shift_byte = {cur_state.addr_hold, 1'b0};
                            nxt_state.bit_index  = 4'd0;
                            nxt_state.kind       = KIND_ADDR_W;
                            nxt_state.phase      = PH_TX_LOW;
                            nxt_state.scl_level  = 1'b0;
                            nxt_state.sda_level  = cur_state.addr_hold[6];
                        end
                        PH_RS_LOW: begin
                            nxt_state.phase     = PH_RS_SETUP;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b1;
                        end
                        PH_RS_SETUP: begin
                            nxt_state.phase     = PH_RS_HOLD;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b0;
                        end
                        PH_RS_HOLD: begin
                            nxt_state.shift_byte = {cur_state.addr_hold, 1'b1};
                            nxt_state.bit_index  = 4'd0;
                            nxt_state.kind       = KIND_ADDR_R;
                            nxt_state.phase      = PH_TX_LOW;
                            nxt_state.scl_level  = 1'b0;
                            nxt_state.sda_level  = cur_state.addr_hold[6];
                        end
                        PH_TX_LOW: begin
                            nxt_state.phase     = PH_TX_HIGH;
                            nxt_state.scl_level = 1'b1;
                        end
                        PH_TX_HIGH: begin
                            nxt_state.bit_index = bit_inc;
                            if (bit_inc < 4'd8) begin
                                nxt_state.shift_byte = {cur_state.shift_byte[6:0], 1'b0};
                                nxt_state.phase      = PH_TX_LOW;
                                nxt_state.scl_level  = 1'b0;
                                nxt_state.sda_level  = cur_state.shift_byte[6];
                            end else begin
                                nxt_state.phase     = PH_TXACK_LOW;
                                nxt_state.scl_level = 1'b0;
                                nxt_state.sda_level = 1'b1;
                            end
                        end
                        PH_TXACK_LOW: begin
                            nxt_state.phase     = PH_TXACK_HIGH;
                            nxt_state.scl_level = 1'b1;
                        end
                        PH_TXACK_HIGH: begin
                            nxt_state.ack_seen = ~tick_in.sda_in;
                            if (tick_in.sda_in) begin
                                // nack: abort with a stop
                                nxt_state.phase     = PH_SP_LOW;
                                nxt_state.scl_level = 1'b0;
                                nxt_state.sda_level = 1'b0;
                            end else begin
                                unique case (cur_state.kind)
                                    KIND_ADDR_W: begin
                                        nxt_state.shift_byte = cur_state.subaddr_hold;
                                        nxt_state.bit_index  = 4'd0;
                                        nxt_state.kind       = KIND_SUB;
                                        nxt_state.phase      = PH_TX_LOW;
                                        nxt_state.scl_level  = 1'b0;
                                        nxt_state.sda_level  = cur_state.subaddr_hold[7];
                                    end
                                    KIND_SUB: begin
                                        if (cur_state.read_flag) begin
                                            nxt_state.phase     = PH_RS_LOW;
                                            nxt_state.scl_level = 1'b0;
                                            nxt_state.sda_level = 1'b1;
                                        end else begin
                                            nxt_state.phase     = PH_WAIT;
                                            nxt_state.scl_level = 1'b0;
                                        end
                                    end
                                    KIND_ADDR_R: begin
                                        nxt_state.shift_byte = 8'd0;
                                        nxt_state.bit_index  = 4'd0;
                                        nxt_state.phase      = PH_RX_LOW;
                                        nxt_state.scl_level  = 1'b0;
                                        nxt_state.sda_level  = 1'b1;
                                    end
                                    default: begin
                                        nxt_state.bytes_left = bytes_dec;
                                        if (bytes_dec == 8'd0) begin
                                            nxt_state.phase     = PH_SP_LOW;
                                            nxt_state.scl_level = 1'b0;
                                            nxt_state.sda_level = 1'b0;
                                        end else begin
                                            nxt_state.phase     = PH_WAIT;
                                            nxt_state.scl_level = 1'b0;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_RX_LOW: begin
                            nxt_state.phase     = PH_RX_HIGH;
                            nxt_state.scl_level = 1'b1;
                        end
                        PH_RX_HIGH: begin
                            nxt_state.shift_byte = {cur_state.shift_byte[6:0],
                                                    tick_in.sda_in};
                            nxt_state.bit_index  = bit_inc;
                            if (bit_inc < 4'd8) begin
                                nxt_state.phase     = PH_RX_LOW;
                                nxt_state.scl_level = 1'b0;
                                nxt_state.sda_level = 1'b1;
                            end else begin
                                // byte complete: ack unless it was the last
                                rdv                  = 1'b1;
                                nxt_state.bytes_left = bytes_dec;
                                nxt_state.phase      = PH_RXACK_LOW;
                                nxt_state.scl_level  = 1'b0;
                                nxt_state.sda_level  = (bytes_dec == 8'd0);
                            end
                        end
                        PH_RXACK_LOW: begin
                            nxt_state.phase     = PH_RXACK_HIGH;
                            nxt_state.scl_level = 1'b1;
                        end
                        PH_RXACK_HIGH: begin
                            if (cur_state.bytes_left == 8'd0) begin
                                nxt_state.phase     = PH_SP_LOW;
                                nxt_state.scl_level = 1'b0;
                                nxt_state.sda_level = 1'b0;
                            end else begin
                                nxt_state.shift_byte = 8'd0;
                                nxt_state.bit_index  = 4'd0;
                                nxt_state.phase      = PH_RX_LOW;
                                nxt_state.scl_level  = 1'b0;
                                nxt_state.sda_level  = 1'b1;
                            end
                        end
                        PH_SP_LOW: begin
                            nxt_state.phase     = PH_SP_HIGH;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b0;
                        end
                        PH_SP_HIGH: begin
                            nxt_state.phase     = PH_SP_DONE;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b1;
                        end
                        PH_SP_DONE: begin
                            nxt_state.phase     = PH_IDLE;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b1;
                            done                = 1'b1;
                        end
                        default: begin
                            nxt_state.phase     = PH_IDLE;
                            nxt_state.scl_level = 1'b1;
                            nxt_state.sda_level = 1'b1;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb begin
        tick_out.scl_out   = nxt_state.scl_level;
        tick_out.sda_out   = nxt_state.sda_level;
        tick_out.busy_res  = (nxt_state.phase != PH_IDLE);
        tick_out.need_data = (nxt_state.phase == PH_WAIT);
        tick_out.rd_data   = rdv ? nxt_state.shift_byte : 8'd0;
        tick_out.rd_valid  = rdv;
        tick_out.done_res  = done;
        tick_out.success   = done & nxt_state.ack_seen;
    end

endmodule
`default_nettype wire

### rtl/core/i2c_master_subaddr_transfer.sv
`timescale 1ns / 1ps
`default_nettype none
// the result item for a tick is registered and appears on m_ in the cycle after it is accepted
// throughput: one tick item per cycle while s_tready is high; the sequencer state updates in a single pass
// s_tready is held low only while a finished result waits and m_tready is low
// reset (aresetn low, synchronous): sequencer idle with both bus lines released,
// half period back to 5 ticks, output register empty
// ----------------------------------------------------------------------------
// i2c_master_subaddr_transfer
// I2C master running one sub-addressed write or read transfer, one tick per item.
// ----------------------------------------------------------------------------
module i2c_master_subaddr_transfer
    import i2cm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: half_period_ticks
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // tdata: start_req, mode, slave_addr[6:0], sub_addr[7:0], byte_count[7:0],
    //        wr_data[7:0], wr_data_valid, sda_in, zero pad
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // tdata: scl_out, sda_out, busy_res, need_data, rd_data[7:0], rd_valid,
    //        done_res, success, zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata
);

    seq_state_t state_reg;
    seq_state_t state_next;
    tick_in_t   tick_in;
    tick_out_t  tick_out;
    logic [7:0] half_period_reg;
    logic       m_tvalid_reg;
    logic [14:0] m_data_reg;
    logic       accept;

    assign tick_in   = s_tdata[34:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_tvalid_reg | m_tready;
    assign accept    = s_tvalid & s_tready;

    i2cm_step u_step (
        .cur_state   (state_reg),
        .tick_in     (tick_in),
        .half_period (half_period_reg),
        .nxt_state   (state_next),
        .tick_out    (tick_out)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_valid) begin
            half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_RESET;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= tick_out;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

endmodule
`default_nettype wire
